>>> src/tlip_pkg.sv
// Shared constants, types and codes of the telnet line input parser.
package tlip_pkg;

  localparam int LINE_MAX = 32;
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  localparam logic [7:0] BYTE_IAC   = 8'hFF;
  localparam logic [7:0] BYTE_SB    = 8'hFA;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_LBRK  = 8'h5B;
  localparam logic [7:0] BYTE_O     = 8'h4F;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef enum logic [3:0] {
    PS_NORMAL  = 4'd0,
    PS_WANT_LF = 4'd1,
    PS_CMD     = 4'd2,
    PS_OPT     = 4'd3,
    PS_SB_IAC  = 4'd4,
    PS_SB_END  = 4'd5,
    PS_ESC1    = 4'd6,
    PS_ESC_O   = 4'd7,
    PS_CSI     = 4'd8
  } parse_state_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_LINE_RD  = 2'd1,
    ST_LINE_OUT = 2'd2,
    ST_LINE_END = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic rd_line;
    logic load_line;
    logic load_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic lf_hit;
    logic len_zero;
    logic idx_last;
  } dp_status_t;

endpackage

>>> src/tlip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/tlip_ctrl.sv
// Controller state machine: input acceptance and sequencing of a completed line.
module tlip_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlip_pkg::dp_status_t status,
  output tlip_pkg::ctrl_cmd_t  cmd
);

  tlip_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlip_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tlip_pkg::ST_IDLE: begin
        if (in_valid && status.out_free && status.lf_hit) begin
          state_next = status.len_zero ? tlip_pkg::ST_LINE_END : tlip_pkg::ST_LINE_RD;
        end
      end
      tlip_pkg::ST_LINE_RD: begin
        state_next = tlip_pkg::ST_LINE_OUT;
      end
      tlip_pkg::ST_LINE_OUT: begin
        if (status.out_free) begin
          state_next = status.idx_last ? tlip_pkg::ST_LINE_END : tlip_pkg::ST_LINE_RD;
        end
      end
      tlip_pkg::ST_LINE_END: begin
        if (status.out_free) begin
          state_next = tlip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tlip_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.rd_line   = 1'b0;
    cmd.load_line = 1'b0;
    cmd.load_end  = 1'b0;
    case (state)
      tlip_pkg::ST_IDLE: begin
        in_ready = status.out_free;
        cmd.take = in_valid && status.out_free;
      end
      tlip_pkg::ST_LINE_RD: begin
        cmd.rd_line = 1'b1;
      end
      tlip_pkg::ST_LINE_OUT: begin
        cmd.load_line = status.out_free;
      end
      tlip_pkg::ST_LINE_END: begin
        cmd.load_end = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> src/tlip_dp.sv
// Datapath: byte parser, line buffer, line length, run index and output register.
module tlip_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  tlip_pkg::ctrl_cmd_t  cmd,
  output tlip_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [7:0]           out_byte,
  output logic                 last
);

  tlip_pkg::parse_state_t parse_state, parse_state_next;
  logic [tlip_pkg::LEN_W-1:0] line_length, line_length_next;
  logic [tlip_pkg::LEN_W-1:0] idx, idx_next;
  logic                       subneg_pending, subneg_pending_next;
  logic                       out_valid_next;
  logic                       echo_en;
  logic [7:0]                 echo_byte;
  logic                       echo_last;
  logic                       buf_we;
  logic [7:0]                 buf_rdata;

  tlip_ram #(
    .WIDTH(8),
    .DEPTH(tlip_pkg::LINE_MAX)
  ) u_line_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(line_length[tlip_pkg::ADDR_W-1:0]),
    .wdata(data_byte),
    .re   (cmd.rd_line),
    .raddr(idx[tlip_pkg::ADDR_W-1:0]),
    .rdata(buf_rdata)
  );

  assign idx_next = idx + tlip_pkg::LEN_W'(1);

  assign status.out_free = !out_valid || out_ready;
  assign status.lf_hit   = (parse_state == tlip_pkg::PS_WANT_LF) &&
                           (data_byte == tlip_pkg::BYTE_LF);
  assign status.len_zero = (line_length == '0);
  assign status.idx_last = (idx_next == line_length);

  always_comb begin
    parse_state_next    = parse_state;
    line_length_next    = line_length;
    subneg_pending_next = subneg_pending;
    echo_en             = 1'b0;
    echo_byte           = data_byte;
    echo_last           = 1'b1;
    buf_we              = 1'b0;
    case (parse_state)
      tlip_pkg::PS_WANT_LF: begin
        if (data_byte == tlip_pkg::BYTE_LF) begin
          echo_en   = 1'b1;
          echo_last = 1'b0;
        end
        parse_state_next = tlip_pkg::PS_NORMAL;
      end
      tlip_pkg::PS_CMD: begin
        subneg_pending_next = (data_byte == tlip_pkg::BYTE_SB);
        parse_state_next    = tlip_pkg::PS_OPT;
      end
      tlip_pkg::PS_OPT: begin
        parse_state_next = subneg_pending ? tlip_pkg::PS_SB_IAC : tlip_pkg::PS_NORMAL;
      end
      tlip_pkg::PS_SB_IAC: begin
        if (data_byte == tlip_pkg::BYTE_IAC) begin
          parse_state_next = tlip_pkg::PS_SB_END;
        end
      end
      tlip_pkg::PS_SB_END, tlip_pkg::PS_ESC_O: begin
        parse_state_next = tlip_pkg::PS_NORMAL;
      end
      tlip_pkg::PS_ESC1: begin
        if (data_byte == tlip_pkg::BYTE_LBRK) begin
          parse_state_next = tlip_pkg::PS_CSI;
        end else if (data_byte == tlip_pkg::BYTE_O) begin
          parse_state_next = tlip_pkg::PS_ESC_O;
        end
      end
      tlip_pkg::PS_CSI: begin
        if (!(data_byte inside {[tlip_pkg::BYTE_ZERO:tlip_pkg::BYTE_NINE],
                                tlip_pkg::BYTE_SEMI})) begin
          parse_state_next = tlip_pkg::PS_NORMAL;
        end
      end
      default: begin
        parse_state_next = tlip_pkg::PS_NORMAL;
        if (data_byte == tlip_pkg::BYTE_IAC) begin
          parse_state_next = tlip_pkg::PS_CMD;
        end else if (data_byte == tlip_pkg::BYTE_ESC) begin
          parse_state_next = tlip_pkg::PS_ESC1;
        end else if (data_byte == tlip_pkg::BYTE_DEL) begin
          if (line_length != '0) begin
            line_length_next = line_length - tlip_pkg::LEN_W'(1);
            echo_en          = 1'b1;
          end
        end else if (data_byte >= tlip_pkg::BYTE_SPACE) begin
          if (line_length < tlip_pkg::LEN_W'(tlip_pkg::LINE_MAX)) begin
            buf_we           = cmd.take;
            line_length_next = line_length + tlip_pkg::LEN_W'(1);
            echo_en          = 1'b1;
          end
        end else if (data_byte == tlip_pkg::BYTE_CR) begin
          echo_en          = 1'b1;
          parse_state_next = tlip_pkg::PS_WANT_LF;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if ((cmd.take && echo_en) || cmd.load_line || cmd.load_end) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= tlip_pkg::PS_NORMAL;
      line_length    <= '0;
      subneg_pending <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (cmd.take) begin
        parse_state    <= parse_state_next;
        line_length    <= line_length_next;
        subneg_pending <= subneg_pending_next;
      end else if (cmd.load_end) begin
        line_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx <= '0;
    end else if (cmd.load_line) begin
      idx <= idx_next;
    end
    if (cmd.take && echo_en) begin
      kind     <= tlip_pkg::KIND_ECHO;
      out_byte <= echo_byte;
      last     <= echo_last;
    end else if (cmd.load_line) begin
      kind     <= tlip_pkg::KIND_LINE;
      out_byte <= buf_rdata;
      last     <= 1'b0;
    end else if (cmd.load_end) begin
      kind     <= tlip_pkg::KIND_END;
      out_byte <= 8'h00;
      last     <= 1'b1;
    end
  end

endmodule

>>> src/telnet_line_input_parser.sv
// Top level of the telnet line input parser.
//
//  channel | direction | tdata          | tuser     | tlast
//  s_axis  | in        | data_byte[7:0] | -         | -
//  m_axis  | out       | out_byte[7:0]  | kind[1:0] | last
//
//  A byte with zero or one result is accepted when the output register is free.
//  CR LF with n buffered bytes gives n + 2 items: LF echo, line bytes, end marker;
//  each line byte is first read from the buffer RAM, then loaded into the output register.
//  s_axis_tready stays low while a completed line is emitted.
//  rst is synchronous, active high; the parser returns to normal text, line empty.
//  A stall on m_axis holds the output register and blocks the next item.
module telnet_line_input_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast
);

  tlip_pkg::ctrl_cmd_t  cmd;
  tlip_pkg::dp_status_t status;

  tlip_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  tlip_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .data_byte(s_axis_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .kind     (m_axis_tuser),
    .out_byte (m_axis_tdata),
    .last     (m_axis_tlast)
  );

endmodule

>>> src/tlip_checker.sv
// Port-level checks of the telnet line input parser, bound to the top level.
module tlip_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tlip_pkg::KIND_END |->
      m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("end marker not last or not zero");

  a_line_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tlip_pkg::KIND_LINE |-> !m_axis_tlast)
    else $error("line byte marked last");

  a_no_input_midrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted before all results of an item were sent");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == tlip_pkg::KIND_ECHO ||
                       m_axis_tuser == tlip_pkg::KIND_LINE ||
                       m_axis_tuser == tlip_pkg::KIND_END))
    else $error("undefined result kind");

endmodule

bind telnet_line_input_parser tlip_checker u_tlip_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

>>> dv/tlip_stream_checker.sv
// Checker for the telnet line input parser: predicts output items and compares them.
module tlip_stream_checker
  import tlip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic [1:0] m_axis_tuser,
  input  logic       m_axis_tlast,
  output int         fail_count,
  output int         pending,
  output int         items_checked,
  output int         lines_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } reply_t;

  reply_t       reply_q[$];
  parse_state_t pstate;
  logic [7:0]   line_buf[LINE_MAX];
  int           line_len;
  logic         sb_pending;
  int           errs;
  int           n_checked;
  int           n_lines;

  initial begin
    errs          = 0;
    n_checked     = 0;
    n_lines       = 0;
    pstate        = PS_NORMAL;
    line_len      = 0;
    sb_pending    = 1'b0;
  end

  function automatic reply_t mk_reply(input logic [1:0] kind, input logic [7:0] data);
    reply_t r;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errs++;
  endtask

  task automatic parse_byte(input logic [7:0] c);
    reply_t batch[$];
    case (pstate)
      PS_WANT_LF: begin
        if (c == BYTE_LF) begin
          batch.push_back(mk_reply(KIND_ECHO, BYTE_LF));
          for (int i = 0; i < line_len; i++) batch.push_back(mk_reply(KIND_LINE, line_buf[i]));
          batch.push_back(mk_reply(KIND_END, 8'h00));
          line_len = 0;
        end
        pstate = PS_NORMAL;
      end
      PS_CMD: begin
        sb_pending = (c == BYTE_SB);
        pstate = PS_OPT;
      end
      PS_OPT: pstate = sb_pending ? PS_SB_IAC : PS_NORMAL;
      PS_SB_IAC: if (c == BYTE_IAC) pstate = PS_SB_END;
      PS_SB_END: pstate = PS_NORMAL;
      PS_ESC1: begin
        if (c == BYTE_LBRK) pstate = PS_CSI;
        else if (c == BYTE_O) pstate = PS_ESC_O;
      end
      PS_ESC_O: pstate = PS_NORMAL;
      PS_CSI: begin
        if (!((c >= BYTE_ZERO && c <= BYTE_NINE) || c == BYTE_SEMI)) pstate = PS_NORMAL;
      end
      default: begin
        pstate = PS_NORMAL;
        if (c == BYTE_IAC) begin
          pstate = PS_CMD;
        end else if (c == BYTE_ESC) begin
          pstate = PS_ESC1;
        end else if (c == BYTE_DEL) begin
          if (line_len > 0) begin
            line_len--;
            batch.push_back(mk_reply(KIND_ECHO, BYTE_DEL));
          end
        end else if (c >= BYTE_SPACE) begin
          if (line_len < LINE_MAX) begin
            line_buf[line_len] = c;
            line_len++;
            batch.push_back(mk_reply(KIND_ECHO, c));
          end
        end else if (c == BYTE_CR) begin
          batch.push_back(mk_reply(KIND_ECHO, BYTE_CR));
          pstate = PS_WANT_LF;
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) reply_q.push_back(batch[i]);
  endtask

  task automatic check_reply(input logic [1:0] kind, input logic [7:0] data, input logic last);
    reply_t exp_r;
    if (reply_q.size() == 0) begin
      report($sformatf("unexpected item kind=%0d byte=%02h last=%0b", kind, data, last));
    end else begin
      exp_r = reply_q.pop_front();
      n_checked++;
      if (kind != exp_r.kind)
        report($sformatf("kind %0d, want %0d (byte %02h)", kind, exp_r.kind, exp_r.data));
      if (data != exp_r.data)
        report($sformatf("byte %02h, want %02h (kind %0d)", data, exp_r.data, exp_r.kind));
      if (last != exp_r.last)
        report($sformatf("last %0b, want %0b (byte %02h)", last, exp_r.last, exp_r.data));
      if (exp_r.kind == KIND_END) n_lines++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reply_q.delete();
      pstate     = PS_NORMAL;
      line_len   = 0;
      sb_pending = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
    pending       <= reply_q.size();
    fail_count    <= errs;
    items_checked <= n_checked;
    lines_done    <= n_lines;
  end

endmodule

>>> dv/tb_telnet_line_input_parser.sv
// Testbench top for the telnet line input parser: stimulus, flow control and verdict.
module tb_telnet_line_input_parser;
  import tlip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  int fail_count;
  int pending;
  int items_checked;
  int lines_done;
  int bytes_sent;
  int random_start;
  bit calm;

  telnet_line_input_parser uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  tlip_stream_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .items_checked(items_checked),
    .lines_done   (lines_done)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_printable();
    logic [7:0] b;
    b = 8'($urandom_range(32, 254));
    if (b == BYTE_DEL) b = 8'h7E;
    return b;
  endfunction

  task automatic send_line(input int len);
    int r;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) push_byte(BYTE_DEL);
      push_byte(rand_printable());
    end
    r = $urandom_range(0, 99);
    if (r < 85) begin
      push_byte(BYTE_CR);
      push_byte(BYTE_LF);
    end else if (r < 95) begin
      push_byte(BYTE_CR);
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_LF) b = 8'h00;
      push_byte(b);
    end
  endtask

  task automatic send_telnet_cmd();
    logic [7:0] cmd;
    logic [7:0] b;
    cmd = ($urandom_range(0, 3) == 0) ? BYTE_SB : 8'($urandom_range(0, 255));
    push_byte(BYTE_IAC);
    push_byte(cmd);
    push_byte(8'($urandom_range(0, 255)));
    if (cmd == BYTE_SB) begin
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom_range(0, 254));
        push_byte(b);
      end
      push_byte(BYTE_IAC);
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_escape();
    int r;
    r = $urandom_range(0, 2);
    push_byte(BYTE_ESC);
    if (r == 0) begin
      push_byte(BYTE_LBRK);
      repeat ($urandom_range(0, 3))
        push_byte(($urandom_range(0, 3) == 0) ? BYTE_SEMI : 8'($urandom_range(48, 57)));
      push_byte(8'($urandom_range(64, 126)));
    end else if (r == 1) begin
      push_byte(BYTE_O);
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_byte(8'($urandom_range(97, 122)));
      push_byte(BYTE_LBRK);
      push_byte(8'($urandom_range(64, 126)));
    end
  endtask

  initial begin
    int r;
    int len;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    bytes_sent    = 0;
    calm          = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_byte(8'h61);
    push_byte(8'hFE);
    push_byte(BYTE_SPACE);
    push_byte(BYTE_DEL);
    push_byte(BYTE_CR);
    push_byte(BYTE_LF);
    push_byte(BYTE_DEL);
    push_byte(8'h00);
    push_byte(8'h7E);
    push_byte(BYTE_IAC);
    push_byte(8'hFB);
    push_byte(8'h01);
    push_byte(BYTE_IAC);
    push_byte(BYTE_SB);
    push_byte(8'h18);
    push_byte(BYTE_IAC);
    push_byte(8'hF0);
    push_byte(BYTE_ESC);
    push_byte(BYTE_LBRK);
    push_byte(8'h39);
    push_byte(BYTE_SEMI);
    push_byte(8'h48);
    push_byte(BYTE_ESC);
    push_byte(8'h7A);
    push_byte(BYTE_O);
    push_byte(8'h41);
    push_byte(BYTE_CR);
    push_byte(8'h71);
    push_byte(BYTE_CR);
    push_byte(BYTE_LF);

    random_start = bytes_sent;
    send_line(LINE_MAX + 2);
    while (bytes_sent - random_start < 110) begin
      if ($urandom_range(0, 6) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(0, 8);
        else if (r < 95) len = $urandom_range(9, LINE_MAX);
        else len = $urandom_range(LINE_MAX - 2, LINE_MAX + 4);
        send_line(len);
      end else if (r < 70) begin
        send_telnet_cmd();
      end else if (r < 85) begin
        send_escape();
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Fed %0d bytes (%0d random) with lines, telnet commands, escapes and noise",
             bytes_sent, bytes_sent - random_start);
    $display("Compared %0d output items, %0d completed lines", items_checked, lines_done);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int g;
    m_axis_tready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d items still expected", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
src/tlip_pkg.sv
src/tlip_ram.sv
src/tlip_ctrl.sv
src/tlip_dp.sv
src/telnet_line_input_parser.sv
src/tlip_checker.sv
dv/tlip_stream_checker.sv
dv/tb_telnet_line_input_parser.sv
